// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the register shadow table.
// Needs clk and rst in the scope of each use; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/rsht_pkg.sv =====
// Package for the register shadow table: sizes, action codes, result type.
// No dependencies.
`default_nettype none

package rsht_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 6;
  localparam int BUFFER_SIZE = 64;
  localparam logic [7:0]  RUN_LIMIT = 8'(BUFFER_SIZE - 6);
  localparam logic [15:0] PEND_BASE = 16'h1000;
  localparam logic [15:0] ADDR_MAX  = 16'hFFFF;

  localparam logic [3:0] ACT_MAP        = 4'd0;
  localparam logic [3:0] ACT_HOST_UPD   = 4'd1;
  localparam logic [3:0] ACT_DISP_UPD   = 4'd2;
  localparam logic [3:0] ACT_READ       = 4'd3;
  localparam logic [3:0] ACT_CLR_PEND   = 4'd4;
  localparam logic [3:0] ACT_FIRST_PEND = 4'd5;
  localparam logic [3:0] ACT_FIRST_RD   = 4'd6;
  localparam logic [3:0] ACT_NEXT_RD    = 4'd7;
  localparam logic [3:0] ACT_RUN_LEN    = 4'd8;

  localparam logic [0:0] CFG_ENABLE = 1'b0;
  localparam logic [0:0] CFG_SIZE   = 1'b1;

  typedef struct packed {
    logic        changed;
    logic [7:0]  run_count;
    logic        found;
    logic [15:0] found_address;
    logic [15:0] read_value;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/register_shadow_table.sv =====
// Register shadow table: entry store, one-entry actions and table scans.
// Depends on rsht_pkg and assert_macros.svh.
//
//  port group   dir  beat contents
//  s_*          in   tuser: action; tdata: entry_index, address, data_value, run_start
//  m_*          out  tdata: read_value, found_address, run_count; tuser: found, changed
//  cfg_*        in   write: index 0 enable, 1 table_size
//
// Entry actions pass through S_ENTRY and S_DONE before the result is registered.
// Searches visit one entry a cycle through a single compare path, over
// min(table_size, 32) entries. Run length rescans from entry 0 after each hit.
// s_tready is high only while idle; a finished result waits in the m_* register.
// Reset clears mapped, pending and value-written bits at once; no sweep.
`default_nettype none

`include "assert_macros.svh"

module register_shadow_table
  import rsht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // entry_index, address, data_value, run_start, pad
  input  wire logic [3:0]  s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // read_value, found_address, run_count
  output logic [1:0]       m_tuser,   // found, changed
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENTRY = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic              enable;
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] used;

  logic [15:0] entry_address [TABLE_DEPTH];
  logic [15:0] entry_value   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_mapped;
  logic [TABLE_DEPTH-1:0] entry_pending;
  logic [TABLE_DEPTH-1:0] value_ok;

  logic [3:0]       act;
  logic [IDX_W-1:0] idx;
  logic [16:0]      addr_q;
  logic [15:0]      data_q;
  logic [15:0]      cur;
  logic [IDX_W-1:0] scan;
  result_t          res;

  logic [IDX_W-1:0] in_idx;
  logic [16:0]      in_addr;
  logic [15:0]      in_data;
  logic [7:0]       in_start;
  logic             in_addr_low;
  logic             accept;

  logic [IDX_W-1:0] sel;
  logic [15:0]      sel_addr;
  logic [15:0]      sel_value;
  logic             sel_mapped;
  logic             inr;
  logic             last;
  logic             qual;
  logic             is_upd;

  assign in_idx   = s_tdata[4:0];
  assign in_addr  = s_tdata[21:5];
  assign in_data  = s_tdata[37:22];
  assign in_start = s_tdata[45:38];
  assign in_addr_low = !in_addr[16] && (in_addr[15:0] != ADDR_MAX);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign used = (table_size > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : table_size;

  assign sel        = (state == S_ENTRY) ? idx : scan;
  assign sel_addr   = entry_address[sel];
  assign sel_mapped = entry_mapped[sel];
  assign sel_value  = value_ok[sel] ? entry_value[sel] : 16'd0;
  assign inr        = {1'b0, idx} < used;
  assign last       = {1'b0, scan} == (used - SIZE_W'(1));
  assign is_upd     = (act == ACT_HOST_UPD) || (act == ACT_DISP_UPD);
  assign qual       = sel_mapped && ((act == ACT_FIRST_RD) || (sel_addr > addr_q[15:0]));

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b1;
      table_size <= SIZE_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: enable     <= cfg_data[0];
        CFG_SIZE:   table_size <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] in_range_addr(input logic [16:0] a);
    in_range_addr = a[16] ? 16'd0 : a[15:0];
  endfunction

  // entry store payload
  always_ff @(posedge clk) begin
    if (state == S_ENTRY && inr) begin
      if (act == ACT_MAP) begin
        entry_address[idx] <= in_range_addr(addr_q);
      end
      if (is_upd && sel_value != data_q) begin
        entry_value[idx] <= data_q;
      end
    end
  end

  // flags per entry
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_mapped  <= '0;
      entry_pending <= '0;
      value_ok      <= '0;
    end else if (state == S_ENTRY && inr) begin
      case (act)
        ACT_MAP: entry_mapped[idx] <= !addr_q[16];
        ACT_HOST_UPD, ACT_DISP_UPD: begin
          if (sel_value != data_q) begin
            value_ok[idx] <= 1'b1;
            if (act == ACT_HOST_UPD) entry_pending[idx] <= 1'b1;
          end
        end
        ACT_CLR_PEND: entry_pending[idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            act    <= s_tuser;
            idx    <= in_idx;
            addr_q <= in_addr;
            data_q <= in_data;
            cur    <= in_addr[15:0] + 16'd1;
            scan   <= '0;
            res    <= '{changed:       1'b0,
                        run_count:     (s_tuser == ACT_RUN_LEN) ? in_start : 8'd0,
                        found:         1'b0,
                        found_address: 16'd0,
                        read_value:    16'd0};
            case (s_tuser)
              ACT_FIRST_PEND, ACT_FIRST_RD:
                state <= (enable && used != '0) ? S_SCAN : S_DONE;
              ACT_NEXT_RD:
                state <= (enable && used != '0 && in_addr_low) ? S_SCAN : S_DONE;
              ACT_RUN_LEN:
                state <= (in_start < RUN_LIMIT && used != '0 && in_addr_low) ? S_RUN : S_DONE;
              default:
                state <= S_ENTRY;
            endcase
          end
        end
        S_ENTRY: begin
          if (inr) begin
            if (act == ACT_READ) res.read_value <= sel_value;
            if (is_upd && sel_value != data_q) res.changed <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (act == ACT_FIRST_PEND) begin
            if (sel_mapped && entry_pending[scan] && sel_addr >= PEND_BASE) begin
              res.found_address <= sel_addr;
              res.found         <= 1'b1;
              state             <= S_DONE;
            end else if (last) begin
              state <= S_DONE;
            end else begin
              scan <= scan + IDX_W'(1);
            end
          end else begin
            if (qual && (!res.found || sel_addr < res.found_address)) begin
              res.found_address <= sel_addr;
              res.found         <= 1'b1;
            end
            if (last) state <= S_DONE;
            else scan <= scan + IDX_W'(1);
          end
        end
        S_RUN: begin
          if (sel_mapped && sel_addr == cur) begin
            res.run_count <= res.run_count + 8'd1;
            cur           <= cur + 16'd1;
            scan          <= '0;
            if (res.run_count + 8'd1 >= RUN_LIMIT || cur == ADDR_MAX) state <= S_DONE;
          end else if (last) begin
            state <= S_DONE;
          end else begin
            scan <= scan + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res.run_count, res.found_address, res.read_value};
            m_tuser  <= {res.changed, res.found};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_nf_zero, m_tvalid && !m_tuser[0] |-> m_tdata[31:16] == 16'd0, "address without hit")
  `ASSERT_NEVER(a_chg_mix, m_tvalid && m_tuser[1] && (m_tuser[0] || m_tdata[39:32] != 8'd0), "mixed result")
  `ASSERT_CLK(a_run_lim, state == S_RUN |-> res.run_count < RUN_LIMIT, "run over limit")
  `ASSERT_CLK(a_scan_rng, state == S_SCAN || state == S_RUN |-> SIZE_W'(scan) < used, "scan beyond table")
  `ASSERT_CLK(a_busy, accept |=> state != S_IDLE, "accept without work")

endmodule

`default_nettype wire
